>>> hdl/dhtd_pkg.sv
// Package: shared types, constants and codes of the deflate token decoder.
package dhtd_pkg;
  localparam int LIT_TABLE_DEPTH_DEF  = 2048;
  localparam int DIST_TABLE_DEPTH_DEF = 1024;
  localparam int MAX_RESULTS          = 8;

  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_LIT  = 2'd1;
  localparam logic [1:0] ACT_DIST = 2'd2;

  localparam logic [1:0] KIND_LIT   = 2'd0;
  localparam logic [1:0] KIND_MATCH = 2'd1;
  localparam logic [1:0] KIND_EOB   = 2'd2;
  localparam logic [1:0] KIND_ERR   = 2'd3;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_TABLE = 2'd1;
  localparam logic [1:0] ERR_FAR   = 2'd2;

  localparam logic [0:0] CFG_LIT_ROOT  = 1'd0;
  localparam logic [0:0] CFG_DIST_ROOT = 1'd1;

  localparam logic [7:0] REDIRECT_TAG = 8'h10;
  localparam logic [3:0] NIB_MASK     = 4'hF;
  localparam logic [16:0] SAT_MAX     = 17'h0FFFF;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic [10:0] table_index;
    logic [31:0] table_word;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  literal;
    logic [15:0] match_length;
    logic [15:0] match_distance;
    logic [1:0]  error_code;
    logic        last;
  } res_t;

  function automatic logic [15:0] low_mask(input logic [3:0] n);
    logic [16:0] m;
    m = (17'd1 << n) - 17'd1;
    return m[15:0];
  endfunction
endpackage

>>> hdl/dhtd_if.sv
// Interfaces: valid/ready request and result channels.
interface dhtd_req_if;
  logic              valid;
  logic              ready;
  dhtd_pkg::req_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface dhtd_res_if;
  logic              valid;
  logic              ready;
  dhtd_pkg::res_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/deflate_huffman_token_decoder_core.sv
// Top level: deflate Huffman token decoder core.
//  channel   dir  handshake            payload
//  in_req    in   valid/ready          action, data_byte, table_index, table_word
//  out_res   out  valid/ready          kind, literal, match_length, match_distance,
//                                      error_code, last
//  cfg       in   cfg_we               cfg_index, cfg_wdata
// A byte is taken in idle, then per symbol: a check, table reads (root and subtable,
// literal/length then distance, each waiting on the registered read of the table RAMs
// unless the index is past the table end), a value step per extra-bit field and an
// emit step. Table writes are done when popped. An output stall holds the emit step.
// Reset is synchronous active low; table contents are not cleared.
// A two-entry queue separates the input from the decoder; output is registered.
module deflate_huffman_token_decoder_core #(
  parameter int LIT_TABLE_DEPTH  = dhtd_pkg::LIT_TABLE_DEPTH_DEF,
  parameter int DIST_TABLE_DEPTH = dhtd_pkg::DIST_TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  dhtd_req_if.sink   in_req,
  dhtd_res_if.source out_res,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [3:0] cfg_wdata
);
  logic           q_valid, q_pop;
  dhtd_pkg::req_t q_data;
  logic [3:0]     lit_root_r, dist_root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lit_root_r  <= 4'd9;
      dist_root_r <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dhtd_pkg::CFG_LIT_ROOT:  lit_root_r  <= cfg_wdata;
        dhtd_pkg::CFG_DIST_ROOT: dist_root_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dhtd_front u_front (
    .clk, .rst_n, .in_req, .q_valid, .q_pop, .q_data);

  dhtd_back #(.LIT_DEPTH(LIT_TABLE_DEPTH), .DIST_DEPTH(DIST_TABLE_DEPTH)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_data,
    .lit_root(lit_root_r), .dist_root(dist_root_r), .out_res);
endmodule

>>> hdl/dhtd_ram.sv
// Generic single-port-write, single-read RAM with registered read.
module dhtd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/dhtd_front.sv
// Front end: accepts requests, decodes actions, queues them for the back end.
module dhtd_front (
  input  logic           clk,
  input  logic           rst_n,
  dhtd_req_if.sink       in_req,
  output logic           q_valid,
  input  logic           q_pop,
  output dhtd_pkg::req_t q_data
);
  localparam int QD = 2;

  dhtd_pkg::req_t q_r [QD];
  logic [0:0] rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_req.ready = (cnt_r != 2'(QD));
  assign push    = in_req.valid && in_req.ready && (in_req.payload.action <= dhtd_pkg::ACT_DIST);
  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = q_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r + 1'(push);
    rd_nxt  = rd_r + 1'(q_pop);
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= '0;
      wr_r  <= '0;
      cnt_r <= '0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wr_r] <= in_req.payload;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'(QD) |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(QD)) else $error("queue count");
endmodule

>>> hdl/dhtd_back.sv
// Back end: bit buffer, table lookups and result generation.
module dhtd_back #(
  parameter int LIT_DEPTH  = dhtd_pkg::LIT_TABLE_DEPTH_DEF,
  parameter int DIST_DEPTH = dhtd_pkg::DIST_TABLE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_pop,
  input  dhtd_pkg::req_t q_data,
  input  logic [3:0]     lit_root,
  input  logic [3:0]     dist_root,
  dhtd_res_if.source     out_res
);
  localparam int LAW = $clog2(LIT_DEPTH);
  localparam int DAW = $clog2(DIST_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_VALUE = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]  st_r, st_nxt;
  logic [63:0] buf_r, buf_nxt;
  logic [6:0]  bcnt_r, bcnt_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic        halt_r, halt_nxt;
  logic [3:0]  k_r, k_nxt;
  logic        isdist_r, isdist_nxt;
  logic        level_r, level_nxt;
  logic [16:0] idx_r, idx_nxt;
  logic [31:0] ent_r, ent_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] dst_r, dst_nxt;
  dhtd_pkg::res_t tok_r, tok_nxt;
  dhtd_pkg::res_t res_r, res_nxt;
  logic        pend_r, pend_nxt;

  logic [31:0] lit_q, dist_q, e;
  logic        lit_we, dist_we;
  logic [16:0] root_idx, sub_idx, vsum;
  logic [3:0]  nb, xb;
  logic [6:0]  bcnt_take;
  logic [63:0] buf_take;
  logic        out_free;

  assign lit_we  = q_pop && q_data.action == dhtd_pkg::ACT_LIT
                   && {2'b0, q_data.table_index} < 13'(LIT_DEPTH);
  assign dist_we = q_pop && q_data.action == dhtd_pkg::ACT_DIST
                   && {2'b0, q_data.table_index} < 13'(DIST_DEPTH);

  dhtd_ram #(.WIDTH(32), .DEPTH(LIT_DEPTH)) u_lit (
    .clk, .we(lit_we), .waddr(LAW'(q_data.table_index)), .wdata(q_data.table_word),
    .raddr(idx_r[LAW-1:0]), .rdata(lit_q));
  dhtd_ram #(.WIDTH(32), .DEPTH(DIST_DEPTH)) u_dist (
    .clk, .we(dist_we), .waddr(DAW'(q_data.table_index)), .wdata(q_data.table_word),
    .raddr(idx_r[DAW-1:0]), .rdata(dist_q));

  assign out_res.valid   = pend_r;
  assign out_res.payload = res_r;
  assign out_free        = !pend_r || out_res.ready;
  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign e     = isdist_r ? dist_q : lit_q;

  always_comb begin
    st_nxt = st_r; buf_nxt = buf_r; bcnt_nxt = bcnt_r; prod_nxt = prod_r;
    halt_nxt = halt_r; k_nxt = k_r; isdist_nxt = isdist_r; level_nxt = level_r;
    idx_nxt = idx_r; ent_nxt = ent_r; len_nxt = len_r; dst_nxt = dst_r;
    tok_nxt = tok_r; res_nxt = res_r;
    pend_nxt = pend_r && !out_res.ready;
    root_idx = '0; sub_idx = '0; vsum = '0; nb = '0; xb = '0;
    bcnt_take = '0; buf_take = '0;
    unique case (st_r)
      S_IDLE: begin
        if (q_pop) begin
          if (q_data.action == dhtd_pkg::ACT_BYTE) begin
            if (bcnt_r <= 7'd56) begin
              buf_nxt  = buf_r | (64'(q_data.data_byte) << bcnt_r);
              bcnt_nxt = bcnt_r + 7'd8;
            end
            k_nxt  = '0;
            st_nxt = S_CHECK;
          end else begin
            halt_nxt = 1'b0;
          end
        end
      end
      S_CHECK: begin
        if (k_r < 4'(dhtd_pkg::MAX_RESULTS) && !halt_r && bcnt_r >= 7'd48) begin
          root_idx   = 17'(buf_r[15:0] & dhtd_pkg::low_mask(lit_root));
          isdist_nxt = 1'b0;
          level_nxt  = 1'b0;
          idx_nxt    = root_idx;
          st_nxt     = S_READ;
        end else begin
          st_nxt = S_IDLE;
        end
      end
      S_READ: begin
        if ((!isdist_r && idx_r >= 17'(LIT_DEPTH)) || (isdist_r && idx_r >= 17'(DIST_DEPTH))) begin
          tok_nxt = '{dhtd_pkg::KIND_ERR, 8'd0, 16'd0, 16'd0, dhtd_pkg::ERR_TABLE, 1'b0};
          halt_nxt = 1'b1;
          st_nxt = S_EMIT;
        end else begin
          st_nxt = S_WAIT;
        end
      end
      S_WAIT: st_nxt = S_EVAL;
      S_EVAL: begin
        ent_nxt = e;
        nb = e[3:0];
        buf_take = buf_r >> nb;
        bcnt_take = (bcnt_r > 7'(nb)) ? bcnt_r - 7'(nb) : 7'd0;
        buf_nxt = buf_take;
        bcnt_nxt = bcnt_take;
        sub_idx = 17'(e[23:8]) + 17'(buf_take[15:0] & dhtd_pkg::low_mask(e[7:4]));
        tok_nxt = '{dhtd_pkg::KIND_ERR, 8'd0, 16'd0, 16'd0, dhtd_pkg::ERR_TABLE, 1'b0};
        if (!isdist_r && e[31]) begin
          tok_nxt = '{dhtd_pkg::KIND_LIT, e[15:8], 16'd0, 16'd0, dhtd_pkg::ERR_NONE, 1'b0};
          prod_nxt = (prod_r == 32'hFFFF_FFFF) ? prod_r : prod_r + 32'd1;
          st_nxt = S_EMIT;
        end else if (e[30] || (isdist_r && e[31])) begin
          st_nxt = S_VALUE;
        end else if (!isdist_r && e[29]) begin
          tok_nxt = '{dhtd_pkg::KIND_EOB, 8'd0, 16'd0, 16'd0, dhtd_pkg::ERR_NONE, 1'b0};
          halt_nxt = 1'b1;
          st_nxt = S_EMIT;
        end else if (e[31:24] != dhtd_pkg::REDIRECT_TAG || level_r) begin
          halt_nxt = 1'b1;
          st_nxt = S_EMIT;
        end else begin
          level_nxt = 1'b1;
          idx_nxt = sub_idx;
          st_nxt = S_READ;
        end
      end
      S_VALUE: begin
        xb = ent_r[7:4];
        vsum = 17'(ent_r[23:8]) + 17'(buf_r[15:0] & dhtd_pkg::low_mask(xb));
        buf_nxt = buf_r >> xb;
        bcnt_nxt = (bcnt_r > 7'(xb)) ? bcnt_r - 7'(xb) : 7'd0;
        if (!isdist_r) begin
          len_nxt = (vsum > dhtd_pkg::SAT_MAX) ? 16'hFFFF : vsum[15:0];
          isdist_nxt = 1'b1;
          level_nxt = 1'b0;
          root_idx = 17'(buf_nxt[15:0] & dhtd_pkg::low_mask(dist_root));
          idx_nxt = root_idx;
          st_nxt = S_READ;
        end else begin
          dst_nxt = (vsum > dhtd_pkg::SAT_MAX) ? 16'hFFFF : vsum[15:0];
          if (32'(dst_nxt) > prod_r) begin
            tok_nxt = '{dhtd_pkg::KIND_ERR, 8'd0, 16'd0, 16'd0, dhtd_pkg::ERR_FAR, 1'b0};
            halt_nxt = 1'b1;
          end else begin
            tok_nxt = '{dhtd_pkg::KIND_MATCH, 8'd0, len_r, dst_nxt, dhtd_pkg::ERR_NONE, 1'b0};
            prod_nxt = (prod_r > 32'hFFFF_FFFF - 32'(len_r)) ? 32'hFFFF_FFFF
                       : prod_r + 32'(len_r);
          end
          st_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          res_nxt = tok_r;
          res_nxt.last = halt_r || (k_r + 4'd1 >= 4'(dhtd_pkg::MAX_RESULTS))
                         || bcnt_r < 7'd48;
          pend_nxt = 1'b1;
          k_nxt = k_r + 4'd1;
          st_nxt = S_CHECK;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; buf_r <= '0; bcnt_r <= '0; prod_r <= '0; halt_r <= 1'b0;
      k_r <= '0; pend_r <= 1'b0; isdist_r <= 1'b0; level_r <= 1'b0;
      idx_r <= '0;
    end else begin
      st_r <= st_nxt; buf_r <= buf_nxt; bcnt_r <= bcnt_nxt; prod_r <= prod_nxt;
      halt_r <= halt_nxt; k_r <= k_nxt; pend_r <= pend_nxt;
      isdist_r <= isdist_nxt; level_r <= level_nxt; idx_r <= idx_nxt;
    end
    ent_r <= ent_nxt; len_r <= len_nxt; dst_r <= dst_nxt;
    tok_r <= tok_nxt; res_r <= res_nxt;
  end

  a_bcnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    bcnt_r <= 7'd64) else $error("bit count overflow");
  a_k_max: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= 4'(dhtd_pkg::MAX_RESULTS)) else $error("result count");
  a_halt_emit: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_CHECK && halt_r |=> st_r == S_IDLE) else $error("decode while halted");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> st_r == S_IDLE) else $error("pop while busy");
endmodule

>>> sim/tb_dhtd_checker.sv
// Checker: watches the channels, predicts decoded tokens and compares them.
`timescale 1ns / 100ps
module tb_dhtd_checker #(
  parameter int LIT_DEPTH  = dhtd_pkg::LIT_TABLE_DEPTH_DEF,
  parameter int DIST_DEPTH = dhtd_pkg::DIST_TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  dhtd_req_if        req,
  dhtd_res_if        res,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [3:0] cfg_wdata,
  output int         fail_count,
  output int         outstanding
);
  typedef enum int {SYM_LIT, SYM_VAL, SYM_EOB, SYM_ERR} sym_cls_t;

  logic [31:0] lit_mem [LIT_DEPTH];
  logic [31:0] dist_mem [DIST_DEPTH];
  logic [63:0] bitbuf;
  int unsigned nbits;
  logic [31:0] produced;
  bit          halted;
  logic [3:0]  lit_root;
  logic [3:0]  dist_root;
  dhtd_pkg::res_t token_q[$];

  function automatic logic [15:0] peek_bits(logic [3:0] n);
    return 16'(bitbuf & ((64'd1 << n) - 64'd1));
  endfunction

  function automatic logic [15:0] take_bits(logic [3:0] n);
    logic [15:0] v;
    v = peek_bits(n);
    bitbuf = bitbuf >> n;
    nbits = (nbits > n) ? nbits - n : 0;
    return v;
  endfunction

  function automatic sym_cls_t walk_table(bit is_lit, logic [3:0] root,
                                          output logic [31:0] ent);
    int unsigned idx;
    logic [31:0] e;
    idx = peek_bits(root);
    ent = '0;
    for (int lvl = 0; lvl < 2; lvl++) begin
      if (idx >= (is_lit ? LIT_DEPTH : DIST_DEPTH)) return SYM_ERR;
      e = is_lit ? lit_mem[idx] : dist_mem[idx];
      ent = e;
      void'(take_bits(e[3:0]));
      if (is_lit) begin
        if (e[31]) return SYM_LIT;
        if (e[30]) return SYM_VAL;
        if (e[29]) return SYM_EOB;
      end else if (e[31:30] != 2'b00) begin
        return SYM_VAL;
      end
      if (e[31:24] != dhtd_pkg::REDIRECT_TAG || lvl == 1) return SYM_ERR;
      idx = int'(e[23:8]) + int'(peek_bits(e[7:4]));
    end
    return SYM_ERR;
  endfunction

  function automatic logic [15:0] entry_value(logic [31:0] e);
    logic [16:0] v;
    v = {1'b0, e[23:8]} + {1'b0, take_bits(e[7:4])};
    return (v > dhtd_pkg::SAT_MAX) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic void add_produced(logic [31:0] n);
    logic [32:0] s;
    s = {1'b0, produced} + {1'b0, n};
    produced = s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void push_token(logic [1:0] kind, logic [7:0] lit,
                                     logic [15:0] len, logic [15:0] dst_v,
                                     logic [1:0] err);
    dhtd_pkg::res_t t;
    t = '{kind, lit, len, dst_v, err, 1'b0};
    token_q.push_back(t);
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    int k;
    logic [31:0] e;
    logic [15:0] len, dst_v;
    sym_cls_t c;
    k = 0;
    if (nbits <= 56) begin
      bitbuf = bitbuf | (64'(b) << nbits);
      nbits += 8;
    end
    while (k < dhtd_pkg::MAX_RESULTS && !halted && nbits >= 48) begin
      c = walk_table(1'b1, lit_root, e);
      k++;
      if (c == SYM_LIT) begin
        push_token(dhtd_pkg::KIND_LIT, e[15:8], '0, '0, dhtd_pkg::ERR_NONE);
        add_produced(32'd1);
        continue;
      end
      if (c != SYM_VAL) begin
        if (c == SYM_EOB) push_token(dhtd_pkg::KIND_EOB, '0, '0, '0, dhtd_pkg::ERR_NONE);
        else push_token(dhtd_pkg::KIND_ERR, '0, '0, '0, dhtd_pkg::ERR_TABLE);
        halted = 1'b1;
        break;
      end
      len = entry_value(e);
      c = walk_table(1'b0, dist_root, e);
      if (c != SYM_VAL) begin
        push_token(dhtd_pkg::KIND_ERR, '0, '0, '0, dhtd_pkg::ERR_TABLE);
        halted = 1'b1;
        break;
      end
      dst_v = entry_value(e);
      if (32'(dst_v) > produced) begin
        push_token(dhtd_pkg::KIND_ERR, '0, '0, '0, dhtd_pkg::ERR_FAR);
        halted = 1'b1;
        break;
      end
      push_token(dhtd_pkg::KIND_MATCH, '0, len, dst_v, dhtd_pkg::ERR_NONE);
      add_produced(32'(len));
    end
    if (k > 0) token_q[token_q.size() - 1].last = 1'b1;
  endfunction

  function automatic void cmp_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  initial begin
    fail_count = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    dhtd_pkg::res_t got, want;
    dhtd_pkg::req_t r;
    if (!rst_n) begin
      bitbuf = '0;
      nbits = 0;
      produced = '0;
      halted = 1'b0;
      lit_root = 4'd9;
      dist_root = 4'd8;
      token_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == dhtd_pkg::CFG_LIT_ROOT) lit_root = cfg_wdata;
        else dist_root = cfg_wdata;
      end
      if (res.valid && res.ready) begin
        got = res.payload;
        if (token_q.size() == 0) begin
          $display("%0t: unexpected token: expected none actual %h", $time, got);
          fail_count++;
        end else begin
          want = token_q.pop_front();
          cmp_field("kind", want.kind, got.kind);
          cmp_field("literal", want.literal, got.literal);
          cmp_field("match_length", want.match_length, got.match_length);
          cmp_field("match_distance", want.match_distance, got.match_distance);
          cmp_field("error_code", want.error_code, got.error_code);
          cmp_field("last", want.last, got.last);
        end
      end
      if (req.valid && req.ready) begin
        r = req.payload;
        case (r.action)
          dhtd_pkg::ACT_BYTE: decode_byte(r.data_byte);
          dhtd_pkg::ACT_LIT: begin
            if (r.table_index < LIT_DEPTH) lit_mem[r.table_index] = r.table_word;
            halted = 1'b0;
          end
          dhtd_pkg::ACT_DIST: begin
            if (r.table_index < DIST_DEPTH) dist_mem[r.table_index] = r.table_word;
            halted = 1'b0;
          end
          default: ;
        endcase
      end
    end
    outstanding = token_q.size();
  end
endmodule

>>> sim/tb_deflate_huffman_token_decoder_core.sv
// Testbench top: drives requests and table loads, gives the verdict.
`timescale 1ns / 100ps
module tb_deflate_huffman_token_decoder_core;
  localparam int LIT_DEPTH   = 512;
  localparam int DIST_DEPTH  = 256;
  localparam int SETTLE      = 250;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [1:0] ACT_NOP = 2'd3;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [3:0] cfg_wdata = '0;
  int         fail_count, outstanding;
  int         cyc = 0;
  bit         calm = 1'b1;

  dhtd_req_if req_ch ();
  dhtd_res_if res_ch ();

  deflate_huffman_token_decoder_core #(
    .LIT_TABLE_DEPTH(LIT_DEPTH), .DIST_TABLE_DEPTH(DIST_DEPTH)
  ) uut (
    .clk(clk), .rst_n(rst_n), .in_req(req_ch), .out_res(res_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  tb_dhtd_checker #(.LIT_DEPTH(LIT_DEPTH), .DIST_DEPTH(DIST_DEPTH)) chk (
    .clk(clk), .rst_n(rst_n), .req(req_ch), .res(res_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("tb_deflate_huffman_token_decoder_core NOT OK");
      $finish;
    end
  end

  initial begin
    int stall;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    res_ch.ready = 1'b0;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        @(negedge clk) res_ch.ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) res_ch.ready = 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  task automatic send(input logic [1:0] act, input logic [7:0] b,
                      input logic [10:0] ix, input logic [31:0] w);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.payload = '{act, b, ix, w};
    req_ch.valid = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic put_lit(input logic [10:0] ix, input logic [31:0] w);
    send(dhtd_pkg::ACT_LIT, 8'($urandom), ix, w);
  endtask

  task automatic put_dist(input logic [10:0] ix, input logic [31:0] w);
    send(dhtd_pkg::ACT_DIST, 8'($urandom), ix, w);
  endtask

  task automatic feed(input logic [7:0] b, input int n);
    repeat (n) send(dhtd_pkg::ACT_BYTE, b, 11'($urandom), $urandom);
  endtask

  // stop the sender, wait for every token, then let the decoder settle
  task automatic drain();
    @(negedge clk) req_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_roots(input logic [3:0] lit_bits, input logic [3:0] dist_bits);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = dhtd_pkg::CFG_LIT_ROOT; cfg_wdata = lit_bits;
    @(negedge clk);
    cfg_index = dhtd_pkg::CFG_DIST_ROOT; cfg_wdata = dist_bits;
    @(negedge clk) cfg_we = 1'b0;
  endtask

  function automatic logic [31:0] rand_lit_entry();
    int p;
    logic [31:0] w;
    p = $urandom_range(0, 99);
    w = $urandom;
    if (p < 45) begin
      w[31] = 1'b1;
      w[3:0] = ($urandom_range(0, 19) == 0) ? 4'd0 : 4'($urandom_range(1, 9));
    end else if (p < 67) begin
      w[31:30] = 2'b01;
      w[23:8] = ($urandom_range(0, 49) == 0) ? 16'hFFFF : 16'($urandom_range(3, 258));
      w[7:4] = 4'($urandom_range(0, 5));
      w[3:0] = 4'($urandom_range(1, 9));
    end else if (p < 71) begin
      w[31:29] = 3'b001;
    end else if (p < 90) begin
      w[31:24] = dhtd_pkg::REDIRECT_TAG;
      w[23:8] = ($urandom_range(0, 19) == 0) ? 16'hFFFF : 16'($urandom_range(0, LIT_DEPTH - 1));
      w[7:4] = 4'($urandom_range(1, 4));
      w[3:0] = 4'($urandom_range(1, 9));
    end else begin
      w[31:29] = 3'b000;
    end
    return w;
  endfunction

  function automatic logic [31:0] rand_dist_entry();
    int p;
    logic [31:0] w;
    p = $urandom_range(0, 99);
    w = $urandom;
    if (p < 72) begin
      if (w[31:30] == 2'b00) w[30] = 1'b1;
      w[23:8] = ($urandom_range(0, 29) == 0) ? 16'hFFFF : 16'($urandom_range(0, 40));
      w[7:4] = 4'($urandom_range(0, 4));
      w[3:0] = 4'($urandom_range(1, 8));
    end else if (p < 88) begin
      w[31:24] = dhtd_pkg::REDIRECT_TAG;
      w[23:8] = 16'($urandom_range(0, DIST_DEPTH - 1));
      w[7:4] = 4'($urandom_range(1, 4));
      w[3:0] = 4'($urandom_range(1, 8));
    end else begin
      w[31:30] = 2'b00;
    end
    return w;
  endfunction

  task automatic random_requests(input int n);
    int p;
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) calm = ($urandom_range(0, 3) == 0);
      p = $urandom_range(0, 99);
      if (p < 72) send(dhtd_pkg::ACT_BYTE, 8'($urandom), 11'($urandom), $urandom);
      else if (p < 84) put_lit(11'($urandom_range(0, 2047)), rand_lit_entry());
      else if (p < 95) put_dist(11'($urandom_range(0, 2047)), rand_dist_entry());
      else send(ACT_NOP, 8'($urandom), 11'($urandom), $urandom);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // every table entry gets written before any lookup
    for (int i = 0; i < LIT_DEPTH; i++) put_lit(11'(i), rand_lit_entry());
    for (int i = 0; i < DIST_DEPTH; i++) put_dist(11'(i), rand_dist_entry());
    drain();

    // directed: zero bytes keep the root lookups at entry 0
    calm = 1'b0;
    put_lit(11'd0, 32'h8000_AB00);       // zero-bit literal: eight per byte
    feed(8'h00, 7);
    put_lit(11'd0, 32'h4000_0301);
    put_dist(11'd0, 32'h4003_E801);      // distance too far back
    feed(8'h00, 1);
    put_dist(11'd0, 32'h8000_0221);
    feed(8'h00, 1);
    put_lit(11'd0, 32'h1000_0523);       // redirect into subtable
    put_lit(11'd5, 32'h8000_5A01);
    feed(8'h00, 1);
    put_lit(11'd5, 32'h1000_0011);       // nested redirect
    feed(8'h00, 1);
    put_lit(11'd0, 32'h10FF_FF11);       // subtable index past the end
    feed(8'h00, 1);
    put_lit(11'd0, 32'h4000_0301);
    put_dist(11'd0, 32'h0000_0001);      // bad distance entry
    feed(8'h00, 1);
    put_lit(11'd0, 32'h2000_0001);       // end of block, then full buffer
    feed(8'hFF, 3);
    put_lit(11'd0, 32'h4000_00FF);       // bit underrun
    put_dist(11'd0, 32'h4000_00FF);
    feed(8'h00, 1);
    put_dist(11'd2047, 32'hFFFF_FFFF);
    send(ACT_NOP, 8'hFF, 11'h7FF, 32'hFFFF_FFFF);
    drain();

    set_roots(4'd1, 4'd1);
    random_requests(40);
    drain();
    set_roots(4'd11, 4'd10);
    random_requests(40);
    drain();
    set_roots(4'($urandom_range(1, 11)), 4'($urandom_range(1, 10)));
    random_requests(40);
    drain();
    set_roots(4'd9, 4'd8);
    random_requests(40);
    drain();
    set_roots(4'($urandom_range(1, 11)), 4'($urandom_range(1, 10)));
    random_requests(40);
    drain();

    // saturation of length and distance
    set_roots(4'd1, 4'd1);
    put_lit(11'd0, 32'h40FF_FF41);
    put_lit(11'd1, 32'h40FF_FF41);
    put_dist(11'd0, 32'h4000_0001);
    put_dist(11'd1, 32'h4000_0001);
    feed(8'($urandom), 8);
    put_dist(11'd0, 32'h40FF_FF41);
    put_dist(11'd1, 32'h40FF_FF41);
    feed(8'($urandom), 8);
    drain();

    if (fail_count == 0) begin
      $display("tb_deflate_huffman_token_decoder_core OK");
    end else begin
      $display("tb_deflate_huffman_token_decoder_core NOT OK");
    end
    $finish;
  end
endmodule
